// ----- src/bmrs_pkg.sv -----
// Shared types and constants for the bitmap run statistics block.
`default_nettype none

package bmrs_pkg;

  // Field widths
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned NBITS_W    = 4;   // bit_count field
  localparam int unsigned COUNT_W    = 17;  // bit counters and span length
  localparam int unsigned SUM_W      = COUNT_W + 1;
  localparam int unsigned RUNS_W     = 16;  // run counter
  localparam int unsigned BYTE_CNT_W = 4;   // 0..8 bits of one byte
  localparam int unsigned BYTE_RUN_W = 3;   // at most 4 run starts in one byte
  localparam int unsigned BIT_IDX_W  = 3;   // index into one byte

  // Commands
  typedef enum logic [1:0] {
    CMD_BYTE       = 2'd0,
    CMD_SET_SPAN   = 2'd1,
    CMD_CLEAR_SPAN = 2'd2,
    CMD_FLUSH      = 2'd3
  } cmd_e;

  // One input item
  typedef struct packed {
    cmd_e                 command;
    logic [BYTE_BITS-1:0] data_byte;
    logic [NBITS_W-1:0]   bit_count;
    logic [COUNT_W-1:0]   span_length;
  } item_t;

  // One result item
  typedef struct packed {
    logic [COUNT_W-1:0] total_bits;
    logic [COUNT_W-1:0] clear_bits;
    logic [COUNT_W-1:0] set_bits;
    logic [RUNS_W-1:0]  clear_runs;
  } result_t;

  // Summary of one partial byte, from the byte scanner to the accumulator
  typedef struct packed {
    logic [BYTE_CNT_W-1:0] set_cnt;
    logic [BYTE_CNT_W-1:0] clr_cnt;
    logic [BYTE_RUN_W-1:0] run_cnt;
    logic                  last_bit;
    logic                  any_bits;
  } scan_t;

endpackage

`default_nettype wire

// ----- src/bmrs_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface bmrs_in_if;
  logic              valid;
  logic              ready;
  bmrs_pkg::item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bmrs_out_if;
  logic              valid;
  logic              ready;
  bmrs_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/bmrs_byte_scan.sv -----
// Scans the relevant low bits of one bitmap byte: set/clear counts, run starts, last bit.
`default_nettype none

module bmrs_byte_scan (
  input  logic [bmrs_pkg::BYTE_BITS-1:0] data_byte_i,
  input  logic [bmrs_pkg::NBITS_W-1:0]   bit_count_i,
  input  logic                           run_start_i,  // a clear bit 0 opens a run
  output bmrs_pkg::scan_t                scan_o
);
  import bmrs_pkg::*;

  logic [BYTE_CNT_W-1:0] n_eff;
  logic [BYTE_CNT_W-1:0] n_m1;
  logic [BYTE_BITS-1:0]  bit_en;
  logic [BYTE_BITS-1:0]  opens;

  // Clamp bit count to one byte and build the lane enables
  always_comb begin
    n_eff = (bit_count_i > NBITS_W'(BYTE_BITS)) ? BYTE_CNT_W'(BYTE_BITS)
                                                : BYTE_CNT_W'(bit_count_i);
    for (int i = 0; i < BYTE_BITS; i++) begin
      bit_en[i] = (BYTE_CNT_W'(i) < n_eff);
    end
  end

  assign n_m1 = n_eff - BYTE_CNT_W'(1);

  // A clear bit opens a run when the bit before it is set (bit 0: when run_start_i)
  always_comb begin
    opens[0] = bit_en[0] & ~data_byte_i[0] & run_start_i;
    for (int i = 1; i < BYTE_BITS; i++) begin
      opens[i] = bit_en[i] & ~data_byte_i[i] & data_byte_i[i-1];
    end
  end

  // Per-byte counts
  always_comb begin
    scan_o.set_cnt = '0;
    scan_o.clr_cnt = '0;
    scan_o.run_cnt = '0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      scan_o.set_cnt = scan_o.set_cnt + BYTE_CNT_W'(bit_en[i] & data_byte_i[i]);
      scan_o.clr_cnt = scan_o.clr_cnt + BYTE_CNT_W'(bit_en[i] & ~data_byte_i[i]);
      scan_o.run_cnt = scan_o.run_cnt + BYTE_RUN_W'(opens[i]);
    end
    scan_o.any_bits = (n_eff != '0);
    scan_o.last_bit = data_byte_i[n_m1[BIT_IDX_W-1:0]];
  end

endmodule

`default_nettype wire

// ----- src/bmrs_accum.sv -----
// Saturating statistics counters and run-edge tracking for one container.
`default_nettype none

module bmrs_accum #(
  parameter int unsigned CONTAINER_BITS = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,       // staged item is consumed this cycle
  input  bmrs_pkg::item_t   item_i,
  input  bmrs_pkg::scan_t   scan_i,
  output logic              run_start_o,  // next clear bit opens a run
  output logic              emit_o,       // flush of a non-empty container
  output bmrs_pkg::result_t result_o
);
  import bmrs_pkg::*;

  localparam int unsigned BITS_CAP = (CONTAINER_BITS < 131071) ? CONTAINER_BITS : 131071;
  localparam int unsigned RUNS_CAP = ((CONTAINER_BITS + 1) / 2 < 65535)
                                     ? (CONTAINER_BITS + 1) / 2 : 65535;
  localparam logic [SUM_W-1:0]  BITS_LIM = SUM_W'(BITS_CAP);
  localparam logic [RUNS_W:0]   RUNS_LIM = (RUNS_W + 1)'(RUNS_CAP);

  logic [COUNT_W-1:0] bits_q, bits_d;
  logic [COUNT_W-1:0] clear_q, clear_d;
  logic [COUNT_W-1:0] set_q, set_d;
  logic [RUNS_W-1:0]  runs_q, runs_d;
  logic               prev_q, prev_d;

  logic [COUNT_W-1:0]    set_add;
  logic [COUNT_W-1:0]    clr_add;
  logic [BYTE_RUN_W-1:0] run_add;
  logic                  new_bit;
  logic                  touch;
  logic                  empty;

  logic [SUM_W-1:0]  bits_sum, clear_sum, set_sum;
  logic [SUM_W-1:0]  bits_sat, clear_sat, set_sat;
  logic [RUNS_W:0]   runs_sum, runs_sat;

  assign empty       = (bits_q == '0);
  assign run_start_o = empty | prev_q;
  assign emit_o      = take_i && (item_i.command == CMD_FLUSH) && !empty;

  assign result_o.total_bits = bits_q;
  assign result_o.clear_bits = clear_q;
  assign result_o.set_bits   = set_q;
  assign result_o.clear_runs = runs_q;

  // Command decode: what this item adds to each counter
  always_comb begin
    set_add = '0;
    clr_add = '0;
    run_add = '0;
    new_bit = prev_q;
    touch   = 1'b0;
    unique case (item_i.command)
      CMD_BYTE: begin
        set_add = COUNT_W'(scan_i.set_cnt);
        clr_add = COUNT_W'(scan_i.clr_cnt);
        run_add = scan_i.run_cnt;
        new_bit = scan_i.last_bit;
        touch   = scan_i.any_bits;
      end
      CMD_SET_SPAN: begin
        set_add = item_i.span_length;
        new_bit = 1'b1;
        touch   = (item_i.span_length != '0);
      end
      CMD_CLEAR_SPAN: begin
        clr_add = item_i.span_length;
        new_bit = 1'b0;
        touch   = (item_i.span_length != '0);
        run_add = BYTE_RUN_W'(touch & run_start_o);
      end
      CMD_FLUSH: begin
        touch = 1'b0;
      end
      default: begin
        touch = 1'b0;
      end
    endcase
  end

  // Saturating sums
  always_comb begin
    bits_sum  = SUM_W'(bits_q) + SUM_W'(set_add) + SUM_W'(clr_add);
    clear_sum = SUM_W'(clear_q) + SUM_W'(clr_add);
    set_sum   = SUM_W'(set_q) + SUM_W'(set_add);
    runs_sum  = (RUNS_W + 1)'(runs_q) + (RUNS_W + 1)'(run_add);
    bits_sat  = (bits_sum  > BITS_LIM) ? BITS_LIM : bits_sum;
    clear_sat = (clear_sum > BITS_LIM) ? BITS_LIM : clear_sum;
    set_sat   = (set_sum   > BITS_LIM) ? BITS_LIM : set_sum;
    runs_sat  = (runs_sum  > RUNS_LIM) ? RUNS_LIM : runs_sum;
  end

  // Next state: update on bits, clear on flush
  always_comb begin
    bits_d  = bits_q;
    clear_d = clear_q;
    set_d   = set_q;
    runs_d  = runs_q;
    prev_d  = prev_q;
    if (take_i) begin
      if (item_i.command == CMD_FLUSH) begin
        bits_d  = '0;
        clear_d = '0;
        set_d   = '0;
        runs_d  = '0;
        prev_d  = 1'b0;
      end else if (touch) begin
        bits_d  = bits_sat[COUNT_W-1:0];
        clear_d = clear_sat[COUNT_W-1:0];
        set_d   = set_sat[COUNT_W-1:0];
        runs_d  = runs_sat[RUNS_W-1:0];
        prev_d  = new_bit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      clear_q <= '0;
      set_q   <= '0;
      runs_q  <= '0;
      prev_q  <= 1'b0;
    end else begin
      bits_q  <= bits_d;
      clear_q <= clear_d;
      set_q   <= set_d;
      runs_q  <= runs_d;
      prev_q  <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bitmap_run_statistics.sv -----
// Top level of the bitmap run statistics block.
`default_nettype none

// Takes one command per cycle unless a flush stalls (byte of up to 8 bits,
// all-set span, all-clear span, flush) and keeps saturating counts of total,
// set and clear bits and of clear-bit runs for the current container. Each
// command passes an input register and is then folded into the counters;
// the counter update loops through the counter registers and sets the rate
// of one item per clock. A flush of a non-empty container, held in the input
// register, loads the result register, which drives the output; a flush
// of an empty container gives no result. The result register decouples the
// sides: items keep flowing while a result waits, and only a flush stalls
// when the previous result is still untaken. Bit counters saturate at
// CONTAINER_BITS (at most 131071), the run counter at half of it rounded up
// (at most 65535). No clearing pass after reset.
module bitmap_run_statistics #(
  parameter int unsigned CONTAINER_BITS = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmrs_in_if.sink           in_i,
  bmrs_out_if.source        out_o
);
  import bmrs_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_data_q, out_data_d;

  logic    out_space;
  logic    s1_go;
  logic    run_start;
  logic    emit;
  scan_t   scan;
  result_t stats;

  // Handshake: a flush needs room in the result register
  assign out_space  = !out_valid_q || out_o.ready;
  assign s1_go      = s1_valid_q && ((s1_item_q.command != CMD_FLUSH) || out_space);
  assign in_i.ready = !s1_valid_q || s1_go;

  assign s1_valid_d  = in_i.valid | (s1_valid_q & ~s1_go);
  assign out_valid_d = emit | (out_valid_q & ~out_o.ready);
  assign out_data_d  = emit ? stats : out_data_q;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  bmrs_byte_scan u_scan (
    .data_byte_i (s1_item_q.data_byte),
    .bit_count_i (s1_item_q.bit_count),
    .run_start_i (run_start),
    .scan_o      (scan)
  );

  bmrs_accum #(
    .CONTAINER_BITS (CONTAINER_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s1_go),
    .item_i      (s1_item_q),
    .scan_i      (scan),
    .run_start_o (run_start),
    .emit_o      (emit),
    .result_o    (stats)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: input stage loads on transfer
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.payload;
    end
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

// ----- src/bmrs_checker.sv -----
// Port-level checks on results of the bitmap run statistics block, with bind.
`default_nettype none

module bmrs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input bmrs_pkg::result_t out_data_i
);
  import bmrs_pkg::*;

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // Total is never below either part nor above their sum (saturation only lowers it)
  a_total_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.total_bits >= out_data_i.clear_bits) &&
                    (out_data_i.total_bits >= out_data_i.set_bits) &&
                    (SUM_W'(out_data_i.total_bits) <=
                     SUM_W'(out_data_i.clear_bits) + SUM_W'(out_data_i.set_bits)))
    else $error("total bits inconsistent with set and clear counts");

  // Results only for non-empty containers; runs never outnumber clear bits
  a_runs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.total_bits != '0) &&
                    (COUNT_W'(out_data_i.clear_runs) <= out_data_i.clear_bits))
    else $error("empty result or too many clear runs");

endmodule

bind bitmap_run_statistics bmrs_checker u_bmrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);

`default_nettype wire

// ----- dv/tb_bitmap_run_statistics.sv -----
// Bitmap run statistics testbench: directed, saturation, alternating-run, random and backpressure tests.
`default_nettype none

module tb_bitmap_run_statistics;
  import bmrs_pkg::*;

  localparam int unsigned CONTAINER_BITS = 65536;
  localparam int unsigned BITS_CAP = (CONTAINER_BITS < 131071) ? CONTAINER_BITS : 131071;
  localparam int unsigned RUNS_CAP =
      ((CONTAINER_BITS + 1) / 2 < 65535) ? (CONTAINER_BITS + 1) / 2 : 65535;
  localparam int unsigned SPAN_MAX = (1 << COUNT_W) - 1;

  logic clk;
  logic rst_n;

  bmrs_in_if  in_if ();
  bmrs_out_if out_if ();

  bitmap_run_statistics #(
    .CONTAINER_BITS(CONTAINER_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Container counters as the block should hold them
  int unsigned acc_total;
  int unsigned acc_clear;
  int unsigned acc_set;
  int unsigned acc_runs;
  bit          acc_last_bit;

  result_t     stats_due[$];
  int unsigned error_count;
  int unsigned burst_left;
  int unsigned hold_request;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("bitmap_run_statistics verification failed");
    $finish;
  end

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b, int unsigned cap);
    return (a + b > cap) ? cap : a + b;
  endfunction

  // Fold a span of equal bits into the container counters
  function automatic void fold_bits(bit value, int unsigned len);
    if (len == 0) return;
    if (value) begin
      acc_set = sat_sum(acc_set, len, BITS_CAP);
    end else begin
      // a clear run starts at the first bit of the container or after a set bit
      if (acc_total == 0 || acc_last_bit) acc_runs = sat_sum(acc_runs, 1, RUNS_CAP);
      acc_clear = sat_sum(acc_clear, len, BITS_CAP);
    end
    acc_last_bit = value;
    acc_total    = sat_sum(acc_total, len, BITS_CAP);
  endfunction

  function automatic void clear_container();
    acc_total    = 0;
    acc_clear    = 0;
    acc_set      = 0;
    acc_runs     = 0;
    acc_last_bit = 1'b0;
  endfunction

  // Predict the effect of one accepted command
  function automatic void fold_command(item_t it);
    int unsigned n;
    result_t     r;
    case (it.command)
      CMD_BYTE: begin
        n = (it.bit_count > BYTE_BITS) ? BYTE_BITS : it.bit_count;
        for (int i = 0; i < n; i++) fold_bits(it.data_byte[i], 1);
      end
      CMD_SET_SPAN:   fold_bits(1'b1, it.span_length);
      CMD_CLEAR_SPAN: fold_bits(1'b0, it.span_length);
      default: begin
        // flush of an empty container emits nothing
        if (acc_total != 0) begin
          r.total_bits = COUNT_W'(acc_total);
          r.clear_bits = COUNT_W'(acc_clear);
          r.set_bits   = COUNT_W'(acc_set);
          r.clear_runs = RUNS_W'(acc_runs);
          stats_due = {stats_due, r};
          clear_container();
        end
      end
    endcase
  endfunction

  function automatic item_t make_item(cmd_e cmd, logic [7:0] data, logic [3:0] n,
                                      logic [16:0] len);
    item_t it;
    it.command     = cmd;
    it.data_byte   = data;
    it.bit_count   = n;
    it.span_length = len;
    return it;
  endfunction

  function automatic void report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Compare one result transfer with the oldest prediction
  function automatic void check_stats(result_t got);
    result_t exp_r;
    if (stats_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      error_count++;
      return;
    end
    exp_r = stats_due.pop_front();
    if (^got === 1'bx) begin
      $display("%0t: unknown result bits, expected %p, actual %p", $time, exp_r, got);
      error_count++;
      return;
    end
    report_field("total_bits", exp_r.total_bits, got.total_bits);
    report_field("clear_bits", exp_r.clear_bits, got.clear_bits);
    report_field("set_bits",   exp_r.set_bits,   got.set_bits);
    report_field("clear_runs", exp_r.clear_runs, got.clear_runs);
  endfunction

  // Result side: check transfers, stall on a rotating pattern, long hold on request
  initial begin
    logic [15:0] stall_pat;
    int unsigned pat_age;
    int unsigned hold_left;
    stall_pat    = 16'hFFFF;
    pat_age      = 0;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) check_stats(out_if.payload);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          pat_age = $urandom_range(20, 80);
          if ($urandom_range(0, 3) == 0) stall_pat = 16'hFFFF;
          else stall_pat = 16'($urandom);
          if (stall_pat == 16'h0) stall_pat = 16'h0001;
        end
        pat_age--;
        out_if.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // Offer one item, wait for its transfer, then idle if the burst is over
  task automatic send_item(item_t it);
    int unsigned gap;
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    fold_command(it);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // some bursts are long stretches with no idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 12);
    end
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // empty container: flush, zero bit count and zero spans do nothing
    send_item(make_item(CMD_FLUSH, 8'hFF, 4'hF, 17'h1FFFF));
    send_item(make_item(CMD_BYTE, 8'hFF, 4'd0, 17'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
    send_item(make_item(CMD_SET_SPAN, 8'hFF, 4'hF, 17'd0));
    send_item(make_item(CMD_CLEAR_SPAN, 8'hFF, 4'hF, 17'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
    // byte extremes, bit counts above 8, mixed spans
    send_item(make_item(CMD_BYTE, 8'hAA, 4'd8, 17'h1FFFF));
    send_item(make_item(CMD_BYTE, 8'hFF, 4'd15, 17'd0));
    send_item(make_item(CMD_BYTE, 8'h00, 4'd9, 17'h1FFFF));
    send_item(make_item(CMD_BYTE, 8'h01, 4'd1, 17'd0));
    send_item(make_item(CMD_SET_SPAN, 8'h00, 4'd0, 17'd1));
    send_item(make_item(CMD_CLEAR_SPAN, 8'hFF, 4'hF, 17'd3));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
    // single clear bit opening a container
    send_item(make_item(CMD_CLEAR_SPAN, 8'h00, 4'd0, 17'd1));
    send_item(make_item(CMD_FLUSH, 8'hFF, 4'hF, 17'h1FFFF));
    // bit counter saturation, edges still tracked afterwards
    send_item(make_item(CMD_SET_SPAN, 8'h00, 4'd0, 17'd65536));
    send_item(make_item(CMD_CLEAR_SPAN, 8'h00, 4'd0, 17'h1FFFF));
    send_item(make_item(CMD_BYTE, 8'h5A, 4'd8, 17'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
    // one bit from a byte, span field ignored
    send_item(make_item(CMD_BYTE, 8'hFE, 4'd1, 17'h1FFFF));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
    // adjacent clear spans form one run
    send_item(make_item(CMD_CLEAR_SPAN, 8'h00, 4'd0, 17'd65535));
    send_item(make_item(CMD_CLEAR_SPAN, 8'h00, 4'd0, 17'd1));
    send_item(make_item(CMD_SET_SPAN, 8'h00, 4'd0, 17'd2));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
  endtask

  // Alternating bytes: 0x55 opens four runs, 0xAA three, as its bit 0 continues the run from the byte before
  task automatic test_alternating_runs();
    for (int i = 0; i < 100; i++)
      send_item(make_item(CMD_BYTE, (i % 2) ? 8'hAA : 8'h55, 4'd8, 17'($urandom)));
    send_item(make_item(CMD_SET_SPAN, 8'h00, 4'd0, 17'd1));
    send_item(make_item(CMD_CLEAR_SPAN, 8'h00, 4'd0, 17'd5));
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
  endtask

  task automatic test_random_containers(int unsigned n_items);
    int unsigned pick;
    int unsigned len;
    logic [3:0]  n;
    item_t       it;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, SPAN_MAX) : $urandom_range(1, 40);
      n    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      if (pick < 8)       it = make_item(CMD_FLUSH, 8'($urandom), 4'($urandom), 17'($urandom));
      else if (pick < 50) it = make_item(CMD_BYTE, 8'($urandom), n, 17'($urandom));
      else if (pick < 70) it = make_item(CMD_SET_SPAN, 8'($urandom), 4'($urandom), 17'(len));
      else if (pick < 92) it = make_item(CMD_CLEAR_SPAN, 8'($urandom), 4'($urandom), 17'(len));
      else                it = item_t'($urandom_range(0, 31) << (COUNT_W + 12) | $urandom);
      if (pick >= 92) it.span_length = 17'($urandom);
      send_item(it);
    end
    send_item(make_item(CMD_FLUSH, 8'h00, 4'd0, 17'd0));
  endtask

  // Receiver holds off while flushes pile up behind the result register
  task automatic test_backpressure();
    hold_request = 300;
    for (int i = 0; i < 20; i++) begin
      send_item(make_item(CMD_BYTE, 8'($urandom), 4'($urandom_range(1, 8)), 17'($urandom)));
      send_item(make_item(CMD_FLUSH, 8'($urandom), 4'($urandom), 17'($urandom)));
    end
    drain_results();
  endtask

  // Test sequence
  initial begin
    error_count   = 0;
    burst_left    = 0;
    hold_request  = 0;
    clear_container();
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_alternating_runs();
    test_random_containers(850);
    test_backpressure();

    drain_results();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("bitmap_run_statistics verification clean");
    end else begin
      $display("bitmap_run_statistics verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- bitmap_run_statistics.f -----
src/bmrs_pkg.sv
src/bmrs_if.sv
src/bmrs_byte_scan.sv
src/bmrs_accum.sv
src/bitmap_run_statistics.sv
src/bmrs_checker.sv
dv/tb_bitmap_run_statistics.sv
